// ===== design/lint_pkg.sv =====
// ----------------------------------------------------------------------------
// lint_pkg
// Shared words and constants of the 2D line intersection pipeline.
// ----------------------------------------------------------------------------
package lint_pkg;

  // Quotient bits resolved by the divider cells; a quotient at or above
  // 2**QBITS always saturates the coordinate.
  localparam int QBITS = 19;
  localparam int DENW  = 35;
  localparam int NUMW  = 52;
  localparam int THRW  = 34;
  localparam int CMPW  = NUMW + 2;

  localparam logic signed [15:0] Q_MAX = 16'sh7FFF;
  localparam logic signed [15:0] Q_MIN = -16'sh8000;

  typedef struct packed {
    logic signed [15:0] a1_x;
    logic signed [15:0] a1_y;
    logic signed [15:0] a2_x;
    logic signed [15:0] a2_y;
    logic signed [15:0] b1_x;
    logic signed [15:0] b1_y;
    logic signed [15:0] b2_x;
    logic signed [15:0] b2_y;
  } in_word_t;

  typedef struct packed {
    logic               hit;
    logic signed [15:0] cross_x;
    logic signed [15:0] cross_y;
    logic               clipped;
  } out_word_t;

  // Word handed from cell to cell through the divider chain
  typedef struct packed {
    logic               hit;
    logic signed [15:0] a1_x;
    logic signed [15:0] a1_y;
    logic               neg_x;
    logic               neg_y;
    logic               ovf_x;
    logic               ovf_y;
    logic [DENW-1:0]    den;
    logic [NUMW-1:0]    rem_x;
    logic [NUMW-1:0]    rem_y;
    logic [QBITS-1:0]   q_x;
    logic [QBITS-1:0]   q_y;
  } div_word_t;

endpackage

// ===== design/lint_front.sv =====
// ----------------------------------------------------------------------------
// lint_front
// Differences, cross products, scaled numerators and magnitudes, five stages.
// ----------------------------------------------------------------------------
module lint_front import lint_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic [THRW-1:0] thr,
  input  logic            up_valid,
  output logic            up_ready,
  input  in_word_t        up_word,
  output logic            dn_valid,
  input  logic            dn_ready,
  output div_word_t       dn_word
);

  logic [4:0] v_r;
  logic [4:0] adv;

  // Stage 1 registers
  logic signed [16:0] d1x_1_r, d1y_1_r, d2x_1_r, d2y_1_r, e1_1_r, e2_1_r;
  logic signed [15:0] ax_1_r, ay_1_r;
  // Stage 2 registers
  logic signed [33:0] p1_2_r, p2_2_r, p3_2_r, p4_2_r;
  logic signed [16:0] d1x_2_r, d1y_2_r;
  logic signed [15:0] ax_2_r, ay_2_r;
  // Stage 3 registers
  logic signed [DENW-1:0] den_3_r, num_3_r;
  logic signed [16:0] d1x_3_r, d1y_3_r;
  logic signed [15:0] ax_3_r, ay_3_r;
  // Stage 4 registers
  logic signed [NUMW-1:0] nx_4_r, ny_4_r;
  logic [DENW-1:0]    mag_4_r;
  logic               dneg_4_r, hit_4_r;
  logic signed [15:0] ax_4_r, ay_4_r;
  // Stage 5 registers
  div_word_t w_5_r;

  logic [DENW-1:0] mag_3;
  logic            par_3;

  // Advance a stage when it is empty or its successor advances
  assign adv[4] = !v_r[4] || dn_ready;
  assign adv[3] = !v_r[3] || adv[4];
  assign adv[2] = !v_r[2] || adv[3];
  assign adv[1] = !v_r[1] || adv[2];
  assign adv[0] = !v_r[0] || adv[1];
  assign up_ready = adv[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (adv[0]) v_r[0] <= up_valid;
      if (adv[1]) v_r[1] <= v_r[0];
      if (adv[2]) v_r[2] <= v_r[1];
      if (adv[3]) v_r[3] <= v_r[2];
      if (adv[4]) v_r[4] <= v_r[3];
    end
  end

  // Form direction vectors and start offsets
  always_ff @(posedge clk) begin
    if (adv[0]) begin
      d1x_1_r <= 17'(up_word.a2_x) - 17'(up_word.a1_x);
      d1y_1_r <= 17'(up_word.a2_y) - 17'(up_word.a1_y);
      d2x_1_r <= 17'(up_word.b2_x) - 17'(up_word.b1_x);
      d2y_1_r <= 17'(up_word.b2_y) - 17'(up_word.b1_y);
      e1_1_r  <= 17'(up_word.a1_y) - 17'(up_word.b1_y);
      e2_1_r  <= 17'(up_word.a1_x) - 17'(up_word.b1_x);
      ax_1_r  <= up_word.a1_x;
      ay_1_r  <= up_word.a1_y;
    end
  end

  // Multiply the cross product terms
  always_ff @(posedge clk) begin
    if (adv[1]) begin
      p1_2_r  <= 34'(d1x_1_r) * 34'(d2y_1_r);
      p2_2_r  <= 34'(d1y_1_r) * 34'(d2x_1_r);
      p3_2_r  <= 34'(d2x_1_r) * 34'(e1_1_r);
      p4_2_r  <= 34'(d2y_1_r) * 34'(e2_1_r);
      d1x_2_r <= d1x_1_r;
      d1y_2_r <= d1y_1_r;
      ax_2_r  <= ax_1_r;
      ay_2_r  <= ay_1_r;
    end
  end

  // Subtract into denominator and numerator
  always_ff @(posedge clk) begin
    if (adv[2]) begin
      den_3_r <= DENW'(p1_2_r) - DENW'(p2_2_r);
      num_3_r <= DENW'(p3_2_r) - DENW'(p4_2_r);
      d1x_3_r <= d1x_2_r;
      d1y_3_r <= d1y_2_r;
      ax_3_r  <= ax_2_r;
      ay_3_r  <= ay_2_r;
    end
  end

  // Judge parallel lines, scale the numerator by each direction
  assign mag_3 = den_3_r[DENW-1] ? DENW'(-den_3_r) : DENW'(den_3_r);
  assign par_3 = (den_3_r == '0) || (mag_3 < DENW'(thr));

  always_ff @(posedge clk) begin
    if (adv[3]) begin
      nx_4_r   <= NUMW'(num_3_r) * NUMW'(d1x_3_r);
      ny_4_r   <= NUMW'(num_3_r) * NUMW'(d1y_3_r);
      mag_4_r  <= mag_3;
      dneg_4_r <= den_3_r[DENW-1];
      hit_4_r  <= !par_3;
      ax_4_r   <= ax_3_r;
      ay_4_r   <= ay_3_r;
    end
  end

  // Take magnitudes and quotient signs
  always_ff @(posedge clk) begin
    if (adv[4]) begin
      w_5_r.hit   <= hit_4_r;
      w_5_r.a1_x  <= ax_4_r;
      w_5_r.a1_y  <= ay_4_r;
      w_5_r.neg_x <= nx_4_r[NUMW-1] ^ dneg_4_r;
      w_5_r.neg_y <= ny_4_r[NUMW-1] ^ dneg_4_r;
      w_5_r.ovf_x <= 1'b0;
      w_5_r.ovf_y <= 1'b0;
      w_5_r.den   <= mag_4_r;
      w_5_r.rem_x <= nx_4_r[NUMW-1] ? NUMW'(-nx_4_r) : NUMW'(nx_4_r);
      w_5_r.rem_y <= ny_4_r[NUMW-1] ? NUMW'(-ny_4_r) : NUMW'(ny_4_r);
      w_5_r.q_x   <= '0;
      w_5_r.q_y   <= '0;
    end
  end

  assign dn_valid = v_r[4];
  assign dn_word  = w_5_r;

endmodule

// ===== design/lint_cell.sv =====
// ----------------------------------------------------------------------------
// lint_cell
// One restoring division step for both coordinates; the top cell flags
// quotients too large to resolve.
// ----------------------------------------------------------------------------
module lint_cell import lint_pkg::*; #(
  parameter int SHIFT = 0
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      up_valid,
  output logic      up_ready,
  input  div_word_t up_word,
  output logic      dn_valid,
  input  logic      dn_ready,
  output div_word_t dn_word
);

  logic            v_r;
  div_word_t       w_r;
  div_word_t       w_nxt;
  logic [CMPW-1:0] dsh;
  logic            ge_x, ge_y;

  assign up_ready = !v_r || dn_ready;

  // Compare each remainder with the shifted divisor
  assign dsh  = CMPW'(up_word.den) << SHIFT;
  assign ge_x = CMPW'(up_word.rem_x) >= dsh;
  assign ge_y = CMPW'(up_word.rem_y) >= dsh;

  always_comb begin
    w_nxt = up_word;
    if (SHIFT >= QBITS) begin
      w_nxt.ovf_x = ge_x;
      w_nxt.ovf_y = ge_y;
    end else begin
      if (ge_x) begin
        w_nxt.rem_x = NUMW'(CMPW'(up_word.rem_x) - dsh);
        w_nxt.q_x[SHIFT % QBITS] = 1'b1;
      end
      if (ge_y) begin
        w_nxt.rem_y = NUMW'(CMPW'(up_word.rem_y) - dsh);
        w_nxt.q_y[SHIFT % QBITS] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (up_ready) begin
      v_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready) begin
      w_r <= w_nxt;
    end
  end

  assign dn_valid = v_r;
  assign dn_word  = w_r;

endmodule

// ===== design/lint_out.sv =====
// ----------------------------------------------------------------------------
// lint_out
// Sign the quotients, add the start point, saturate and hold the result.
// ----------------------------------------------------------------------------
module lint_out import lint_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      up_valid,
  output logic      up_ready,
  input  div_word_t up_word,
  output logic      dn_valid,
  input  logic      dn_ready,
  output out_word_t dn_word
);

  logic               v_r;
  out_word_t          w_r;
  out_word_t          w_nxt;
  logic signed [20:0] qs_x, qs_y, sum_x, sum_y;
  logic signed [15:0] px, py;
  logic               clp_x, clp_y;

  assign up_ready = !v_r || dn_ready;

  assign qs_x  = up_word.neg_x ? -$signed(21'(up_word.q_x)) : $signed(21'(up_word.q_x));
  assign qs_y  = up_word.neg_y ? -$signed(21'(up_word.q_y)) : $signed(21'(up_word.q_y));
  assign sum_x = 21'(up_word.a1_x) + qs_x;
  assign sum_y = 21'(up_word.a1_y) + qs_y;

  // Saturate x, large quotients go straight to the rail
  always_comb begin
    clp_x = 1'b1;
    if (up_word.ovf_x)                px = up_word.neg_x ? Q_MIN : Q_MAX;
    else if (sum_x > 21'(Q_MAX))      px = Q_MAX;
    else if (sum_x < 21'(Q_MIN))      px = Q_MIN;
    else begin
      px    = sum_x[15:0];
      clp_x = 1'b0;
    end
  end

  // Saturate y
  always_comb begin
    clp_y = 1'b1;
    if (up_word.ovf_y)                py = up_word.neg_y ? Q_MIN : Q_MAX;
    else if (sum_y > 21'(Q_MAX))      py = Q_MAX;
    else if (sum_y < 21'(Q_MIN))      py = Q_MIN;
    else begin
      py    = sum_y[15:0];
      clp_y = 1'b0;
    end
  end

  // Zero the result for parallel lines
  always_comb begin
    w_nxt = '0;
    if (up_word.hit) begin
      w_nxt.hit     = 1'b1;
      w_nxt.cross_x = px;
      w_nxt.cross_y = py;
      w_nxt.clipped = clp_x || clp_y;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (up_ready) begin
      v_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready) begin
      w_r <= w_nxt;
    end
  end

  assign dn_valid = v_r;
  assign dn_word  = w_r;

endmodule

// ===== design/line_intersection_2d.sv =====
// ----------------------------------------------------------------------------
// line_intersection_2d
// Intersection point of two infinite 2D lines in signed Q12.4.
// ----------------------------------------------------------------------------
//  channel  | ports                          | word
//  ---------+--------------------------------+-------------------------------
//  input    | in_valid, in_ready, in_word    | two point pairs, in_word_t
//  result   | out_valid, out_ready, out_word | hit, point, clip, out_word_t
//  config   | cfg_we, cfg_data               | parallel threshold, Q.8
//
//  One word per cycle while out_ready holds; pipeline of five front stages, one
//  division cell per quotient bit plus an overflow cell, and the output stage.
//  Every stage holds its own valid bit, so a stall at out_ready fills the
//  bubbles first and only then pushes back to in_ready.
//  Synchronous active-low reset empties the pipeline and sets the threshold
//  to 1.
// ----------------------------------------------------------------------------
module line_intersection_2d import lint_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  in_word_t        in_word,
  output logic            out_valid,
  input  logic            out_ready,
  output out_word_t       out_word,
  input  logic            cfg_we,
  input  logic [THRW-1:0] cfg_data
);

  localparam int NCELL = QBITS + 1;

  logic [THRW-1:0] thr_r;
  logic            cv [NCELL+1];
  logic            cr [NCELL+1];
  div_word_t       cw [NCELL+1];

  // Hold the threshold register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= THRW'(1);
    end else if (cfg_we) begin
      thr_r <= cfg_data;
    end
  end

  lint_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .thr      (thr_r),
    .up_valid (in_valid),
    .up_ready (in_ready),
    .up_word  (in_word),
    .dn_valid (cv[0]),
    .dn_ready (cr[0]),
    .dn_word  (cw[0])
  );

  // Chain the division cells, highest quotient bit first
  for (genvar i = 0; i < NCELL; i++) begin : g_cell
    lint_cell #(.SHIFT(QBITS - i)) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (cv[i]),
      .up_ready (cr[i]),
      .up_word  (cw[i]),
      .dn_valid (cv[i+1]),
      .dn_ready (cr[i+1]),
      .dn_word  (cw[i+1])
    );
  end

  lint_out u_out (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (cv[NCELL]),
    .up_ready (cr[NCELL]),
    .up_word  (cw[NCELL]),
    .dn_valid (out_valid),
    .dn_ready (out_ready),
    .dn_word  (out_word)
  );

endmodule
